FILE: hw/rtl/tmncc_pkg.sv
// ----------------------------------------------------------------------------
// tmncc_pkg
// Shared types, register codes and constants of the template matcher.
// ----------------------------------------------------------------------------
package tmncc_pkg;

  // input operation codes
  localparam logic OP_TEMPLATE = 1'b0;
  localparam logic OP_IMAGE    = 1'b1;

  // scoring modes
  localparam logic MODE_SQDIFF = 1'b0;
  localparam logic MODE_CCOEFF = 1'b1;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_W = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_H = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TPL_W   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TPL_H   = 3'd4;

  // result field widths
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned ROW_OUT_W = 12;
  localparam int unsigned COL_OUT_W = 10;
  localparam int unsigned SQD_OUT_W = 24;
  localparam int unsigned NCC_W     = 16;

  // correlation magnitude search: result in [0, 2^15]
  localparam int unsigned Q_W  = 16;
  localparam int unsigned K2_W = 32;
  localparam logic [Q_W-1:0]   Q_ONE   = 16'h8000;
  localparam logic [NCC_W-1:0] NCC_MAX = 16'h7FFF;

  typedef struct packed {
    logic             operation;
    logic [PIX_W-1:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [ROW_OUT_W-1:0]    window_row;
    logic [COL_OUT_W-1:0]    window_col;
    logic [SQD_OUT_W-1:0]    sqdiff_score;
    logic signed [NCC_W-1:0] ncc_score;
    logic                    degenerate;
    logic                    last_result;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_item_t;

  // controller -> datapath
  typedef struct packed {
    logic take;      // input request accepted
    logic step;      // scan one window pixel
    logic prod;      // form correlation products
    logic diff;      // variances and numerator
    logic sq;        // variance product and numerator square
    logic k_step;    // next search candidate
    logic mul_lo;    // candidate times low half
    logic mul_hi;    // candidate times high half
    logic cmp;       // compare and narrow
    logic load_out;  // fill result register
  } tmncc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;          // accepted pixel completes a window
    logic scan_last;    // final window pixel being read
    logic mode;
    logic degen;
    logic search_done;
    logic out_free;
  } tmncc_status_t;

endpackage

FILE: hw/rtl/tmncc_stream_if.sv
// ----------------------------------------------------------------------------
// tmncc_stream_if
// Valid/ready channel carrying one request payload.
// ----------------------------------------------------------------------------
interface tmncc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/template_match_sqdiff_ncc.sv
// ----------------------------------------------------------------------------
// template_match_sqdiff_ncc
// Streaming template matcher with squared-difference or normalized
// mean-removed correlation scores.
// ----------------------------------------------------------------------------
// Load the template first (operation 0, raster order), then stream image
// pixels (operation 1, raster order). An image pixel that does not complete
// a window is only stored. One that completes a window starts a scan of the
// window through the line store, one pixel per cycle from its single read
// port. A correlation score then also needs the products, the variances
// and the 16-step magnitude search, each step a candidate, a low and a
// high product and a compare on one 32x32 multiplier path. While a score
// is computed no new pixel is taken; a finished score waits in an output
// register and does not hold up the next pixel. Configuration writes are
// taken in any cycle and belong in idle periods; writing any size register
// restarts the frame and drops the template. Stores come up uninitialized;
// no clearing pass is run.
// ----------------------------------------------------------------------------
module template_match_sqdiff_ncc
  import tmncc_pkg::*;
#(
  parameter int unsigned TEMPLATE_MAX_W = 16,
  parameter int unsigned TEMPLATE_MAX_H = 16,
  parameter int unsigned IMAGE_MAX_W    = 1024,
  parameter int unsigned IMAGE_MAX_H    = 4096
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  tmncc_stream_if.sink   in_i,
  tmncc_stream_if.source out_o,
  tmncc_stream_if.sink   cfg_i
);

  tmncc_cmd_t    cmd;
  tmncc_status_t status;
  logic          in_ready;
  logic          cfg_ready;
  logic          out_valid;
  out_item_t     out_item;
  in_item_t      in_item;
  cfg_item_t     cfg_item;

  assign in_item       = in_i.payload;
  assign cfg_item      = cfg_i.payload;
  assign in_i.ready    = in_ready;
  assign cfg_i.ready   = cfg_ready;
  assign out_o.valid   = out_valid;
  assign out_o.payload = out_item;

  tmncc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tmncc_dp #(
    .TEMPLATE_MAX_W (TEMPLATE_MAX_W),
    .TEMPLATE_MAX_H (TEMPLATE_MAX_H),
    .IMAGE_MAX_W    (IMAGE_MAX_W),
    .IMAGE_MAX_H    (IMAGE_MAX_H)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item),
    .cfg_valid_i (cfg_i.valid),
    .cfg_item_i  (cfg_item),
    .cfg_ready_o (cfg_ready),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .out_item_o  (out_item)
  );

endmodule

FILE: hw/rtl/tmncc_ram.sv
// ----------------------------------------------------------------------------
// tmncc_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tmncc_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 256,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: hw/rtl/tmncc_ctrl.sv
// ----------------------------------------------------------------------------
// tmncc_ctrl
// Sequencer: window scan, correlation arithmetic steps, result hand-off.
// ----------------------------------------------------------------------------
module tmncc_ctrl
  import tmncc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tmncc_status_t status_i,
  output tmncc_cmd_t    cmd_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SCAN  = 4'd1;
  localparam logic [3:0] ST_DRAIN = 4'd2;
  localparam logic [3:0] ST_PROD  = 4'd3;
  localparam logic [3:0] ST_DIFF  = 4'd4;
  localparam logic [3:0] ST_SQ    = 4'd5;
  localparam logic [3:0] ST_K     = 4'd6;
  localparam logic [3:0] ST_MLO   = 4'd7;
  localparam logic [3:0] ST_MHI   = 4'd8;
  localparam logic [3:0] ST_CMP   = 4'd9;
  localparam logic [3:0] ST_OUT   = 4'd10;

  logic [3:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
        if (in_valid_i && status_i.hit) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.step = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = (status_i.mode == MODE_CCOEFF) ? ST_PROD : ST_OUT;
      end
      ST_PROD: begin
        cmd_o.prod = 1'b1;
        state_d    = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = ST_SQ;
      end
      ST_SQ: begin
        cmd_o.sq = 1'b1;
        state_d  = status_i.degen ? ST_OUT : ST_K;
      end
      ST_K: begin
        if (status_i.search_done) begin
          state_d = ST_OUT;
        end else begin
          cmd_o.k_step = 1'b1;
          state_d      = ST_MLO;
        end
      end
      ST_MLO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = ST_MHI;
      end
      ST_MHI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = ST_K;
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/tmncc_dp.sv
// ----------------------------------------------------------------------------
// tmncc_dp
// Datapath: registers, template and line stores, window accumulators,
// correlation arithmetic and the result register.
// ----------------------------------------------------------------------------
module tmncc_dp
  import tmncc_pkg::*;
#(
  parameter int unsigned TEMPLATE_MAX_W = 16,
  parameter int unsigned TEMPLATE_MAX_H = 16,
  parameter int unsigned IMAGE_MAX_W    = 1024,
  parameter int unsigned IMAGE_MAX_H    = 4096
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  in_item_t      in_item_i,
  input  logic          cfg_valid_i,
  input  cfg_item_t     cfg_item_i,
  output logic          cfg_ready_o,
  input  tmncc_cmd_t    cmd_i,
  output tmncc_status_t status_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output out_item_t     out_item_o
);

  localparam int unsigned NMAX    = TEMPLATE_MAX_W * TEMPLATE_MAX_H;
  localparam int unsigned TWC_W   = $clog2(TEMPLATE_MAX_W + 1);
  localparam int unsigned THC_W   = $clog2(TEMPLATE_MAX_H + 1);
  localparam int unsigned IW_W    = $clog2(IMAGE_MAX_W + 1);
  localparam int unsigned IH_W    = $clog2(IMAGE_MAX_H + 1);
  localparam int unsigned COL_W   = $clog2(IMAGE_MAX_W);
  localparam int unsigned ROW_W   = $clog2(IMAGE_MAX_H);
  localparam int unsigned SLOT_W  = (TEMPLATE_MAX_H > 1) ? $clog2(TEMPLATE_MAX_H) : 1;
  localparam int unsigned TA_W    = (NMAX > 1) ? $clog2(NMAX) : 1;
  localparam int unsigned LDEPTH  = TEMPLATE_MAX_H * IMAGE_MAX_W;
  localparam int unsigned LA_W    = $clog2(LDEPTH);
  localparam int unsigned N_W     = $clog2(NMAX + 1);
  localparam int unsigned SUM_W   = $clog2(NMAX * 255 + 1);
  localparam int unsigned SQS_W   = $clog2(NMAX * 65025 + 1);
  localparam int unsigned V_W     = $clog2(longint'(NMAX) * NMAX * 65025 + 1);
  localparam int unsigned PP_W    = 2 * V_W;
  localparam int unsigned MUL_W   = K2_W + V_W;
  localparam int unsigned CMP_W   = PP_W + K2_W;
  localparam int unsigned IW_RST  = (IMAGE_MAX_W < 1024) ? IMAGE_MAX_W : 1024;

  // configuration registers
  logic             mode_q;
  logic [IW_W-1:0]  iw_q;
  logic [IH_W-1:0]  ih_q;
  logic [TWC_W-1:0] tw_q;
  logic [THC_W-1:0] th_q;

  // template state and frame position
  logic [N_W-1:0]    tcount_q;
  logic [SUM_W-1:0]  tsum_q;
  logic [SQS_W-1:0]  tsq_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;
  logic [SLOT_W-1:0] slot_q;

  // current placement and scan
  logic [ROW_W-1:0]  wr_q;
  logic [COL_W-1:0]  wc_q;
  logic              last_q;
  logic [THC_W-1:0]  si_q;
  logic [TWC_W-1:0]  sj_q;
  logic [SLOT_W-1:0] sslot_q;
  logic [LA_W-1:0]   sbase_q;
  logic [TA_W-1:0]   ta_q;
  logic              rd_valid_q;
  logic [SUM_W-1:0]  sw_q;
  logic [SQS_W-1:0]  sww_q, swt_q, sqd_q;

  // correlation arithmetic
  logic [V_W-1:0]   p_nsww_q, p_sw2_q, p_nstt_q, p_st2_q, p_nswt_q, p_swst_q;
  logic [V_W-1:0]   vw_q, vt_q, m_q;
  logic             neg_q, degen_q;
  logic [PP_W-1:0]  pp_q, aa_q;
  logic [Q_W-1:0]   lo_q, hi_q, mid_q;
  logic [K2_W-1:0]  k2_q;
  logic [MUL_W-1:0] pl_q, ph_q;

  // result register
  logic      out_valid_q;
  out_item_t out_q;

  // combinational helpers
  logic [TWC_W-1:0]  tw_e;
  logic [THC_W-1:0]  th_e;
  logic [N_W-1:0]    n_e;
  logic              tpl_full, is_img, hit, size_wr;
  logic [N_W-1:0]    tc_base;
  logic [SUM_W-1:0]  ts_base;
  logic [SQS_W-1:0]  tq_base;
  logic [ROW_W-1:0]  wr_new;
  logic [COL_W-1:0]  wc_new;
  logic              last_new, col_end, row_end;
  logic [SLOT_W-1:0] top_slot, slot_inc, sslot_inc;
  logic [31:0]       top_tmp;
  logic [LA_W-1:0]   line_waddr, line_raddr;
  logic              line_we, tpl_we, scan_last;
  logic [PIX_W-1:0]  line_rdata, tpl_rdata, w_pix, t_pix, d_pix;
  logic [Q_W:0]      mid_sum, k_wide;
  logic [Q_W-1:0]    mid_c;
  logic [CMP_W-1:0]  a_val, b_val;
  logic [NCC_W-1:0]  ncc_val;
  logic [31:0]       iw_cl, ih_cl, tw_cl, th_cl;

  assign cfg_ready_o = 1'b1;

  // effective sizes
  always_comb begin
    tw_e = (32'(tw_q) < 32'(iw_q)) ? tw_q : TWC_W'(iw_q);
    th_e = (32'(th_q) < 32'(ih_q)) ? th_q : THC_W'(ih_q);
    n_e  = N_W'(tw_e) * N_W'(th_e);
  end

  // config value clamping
  always_comb begin
    iw_cl = 32'(cfg_item_i.data[10:0]);
    if (iw_cl == 0) iw_cl = 1;
    else if (iw_cl > IMAGE_MAX_W) iw_cl = IMAGE_MAX_W;
    ih_cl = 32'(cfg_item_i.data[12:0]);
    if (ih_cl == 0) ih_cl = 1;
    else if (ih_cl > IMAGE_MAX_H) ih_cl = IMAGE_MAX_H;
    tw_cl = 32'(cfg_item_i.data[4:0]);
    if (tw_cl == 0) tw_cl = 1;
    else if (tw_cl > TEMPLATE_MAX_W) tw_cl = TEMPLATE_MAX_W;
    th_cl = 32'(cfg_item_i.data[4:0]);
    if (th_cl == 0) th_cl = 1;
    else if (th_cl > TEMPLATE_MAX_H) th_cl = TEMPLATE_MAX_H;
    size_wr = cfg_valid_i && (cfg_item_i.index == REG_IMAGE_W ||
              cfg_item_i.index == REG_IMAGE_H || cfg_item_i.index == REG_TPL_W ||
              cfg_item_i.index == REG_TPL_H);
  end

  // input request decode
  always_comb begin
    tpl_full = tcount_q >= n_e;
    is_img   = in_item_i.operation == OP_IMAGE;
    hit      = is_img && tpl_full && (32'(row_q) + 1 >= 32'(th_e)) &&
               (32'(col_q) + 1 >= 32'(tw_e));
    tc_base  = tpl_full ? '0 : tcount_q;
    ts_base  = tpl_full ? '0 : tsum_q;
    tq_base  = tpl_full ? '0 : tsq_q;
    wr_new   = ROW_W'(32'(row_q) + 1 - 32'(th_e));
    wc_new   = COL_W'(32'(col_q) + 1 - 32'(tw_e));
    last_new = (32'(row_q) + 1 == 32'(ih_q)) && (32'(col_q) + 1 == 32'(iw_q));
    col_end  = 32'(col_q) + 1 >= 32'(iw_q);
    row_end  = 32'(row_q) + 1 >= 32'(ih_q);
    slot_inc = (32'(slot_q) + 1 >= TEMPLATE_MAX_H) ? '0 : SLOT_W'(32'(slot_q) + 1);
    top_tmp  = 32'(slot_q) + TEMPLATE_MAX_H + 1 - 32'(th_e);
    top_slot = (top_tmp >= TEMPLATE_MAX_H) ? SLOT_W'(top_tmp - TEMPLATE_MAX_H)
                                           : SLOT_W'(top_tmp);
    line_we    = cmd_i.take && is_img && tpl_full;
    tpl_we     = cmd_i.take && !is_img;
    line_waddr = LA_W'(slot_q) * LA_W'(IMAGE_MAX_W) + LA_W'(col_q);
  end

  // window scan addressing
  always_comb begin
    sslot_inc  = (32'(sslot_q) + 1 >= TEMPLATE_MAX_H) ? '0 : SLOT_W'(32'(sslot_q) + 1);
    line_raddr = sbase_q + LA_W'(sj_q);
    scan_last  = (32'(si_q) + 1 == 32'(th_e)) && (32'(sj_q) + 1 == 32'(tw_e));
    w_pix      = line_rdata;
    t_pix      = tpl_rdata;
    d_pix      = (w_pix > t_pix) ? w_pix - t_pix : t_pix - w_pix;
  end

  // search candidate and compare
  always_comb begin
    mid_sum = (Q_W+1)'(lo_q) + (Q_W+1)'(hi_q) + (Q_W+1)'(1);
    mid_c   = mid_sum[Q_W:1];
    k_wide  = {mid_c, 1'b0} - (Q_W+1)'(1);
    a_val   = CMP_W'(aa_q) << K2_W;
    b_val   = (CMP_W'(ph_q) << V_W) + CMP_W'(pl_q);
    if (!neg_q) begin
      ncc_val = (lo_q > NCC_MAX) ? NCC_MAX : lo_q;
    end else begin
      ncc_val = NCC_W'(17'h10000 - 17'(lo_q));
    end
  end

  tmncc_ram #(.WIDTH(PIX_W), .DEPTH(NMAX)) u_tpl_ram (
    .clk_i   (clk_i),
    .we_i    (tpl_we),
    .waddr_i (TA_W'(tc_base)),
    .wdata_i (in_item_i.pixel),
    .raddr_i (ta_q),
    .rdata_o (tpl_rdata)
  );

  tmncc_ram #(.WIDTH(PIX_W), .DEPTH(LDEPTH)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (line_waddr),
    .wdata_i (in_item_i.pixel),
    .raddr_i (line_raddr),
    .rdata_o (line_rdata)
  );

  // configuration, template load and frame position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_SQDIFF;
      iw_q     <= IW_W'(IW_RST);
      ih_q     <= IH_W'(1);
      tw_q     <= TWC_W'(1);
      th_q     <= THC_W'(1);
      tcount_q <= '0;
      tsum_q   <= '0;
      tsq_q    <= '0;
      row_q    <= '0;
      col_q    <= '0;
      slot_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_item_i.index)
        REG_MODE:    mode_q <= cfg_item_i.data[0];
        REG_IMAGE_W: iw_q   <= IW_W'(iw_cl);
        REG_IMAGE_H: ih_q   <= IH_W'(ih_cl);
        REG_TPL_W:   tw_q   <= TWC_W'(tw_cl);
        REG_TPL_H:   th_q   <= THC_W'(th_cl);
        default: ;
      endcase
      if (size_wr) begin
        tcount_q <= '0;
        tsum_q   <= '0;
        tsq_q    <= '0;
        row_q    <= '0;
        col_q    <= '0;
        slot_q   <= '0;
      end
    end else if (cmd_i.take) begin
      if (!is_img) begin
        tcount_q <= tc_base + N_W'(1);
        tsum_q   <= ts_base + SUM_W'(in_item_i.pixel);
        tsq_q    <= tq_base + SQS_W'(in_item_i.pixel) * SQS_W'(in_item_i.pixel);
        row_q    <= '0;
        col_q    <= '0;
        slot_q   <= '0;
      end else if (tpl_full) begin
        if (col_end) begin
          col_q <= '0;
          if (row_end) begin
            row_q  <= '0;
            slot_q <= '0;
          end else begin
            row_q  <= row_q + ROW_W'(1);
            slot_q <= slot_inc;
          end
        end else begin
          col_q <= col_q + COL_W'(1);
        end
      end
    end
  end

  // window scan and accumulation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && hit) begin
      wr_q    <= wr_new;
      wc_q    <= wc_new;
      last_q  <= last_new;
      si_q    <= '0;
      sj_q    <= '0;
      ta_q    <= '0;
      sslot_q <= top_slot;
      sbase_q <= LA_W'(top_slot) * LA_W'(IMAGE_MAX_W) + LA_W'(wc_new);
      sw_q    <= '0;
      sww_q   <= '0;
      swt_q   <= '0;
      sqd_q   <= '0;
    end else begin
      if (cmd_i.step) begin
        ta_q <= ta_q + TA_W'(1);
        if (32'(sj_q) + 1 == 32'(tw_e)) begin
          sj_q    <= '0;
          si_q    <= si_q + THC_W'(1);
          sslot_q <= sslot_inc;
          sbase_q <= LA_W'(sslot_inc) * LA_W'(IMAGE_MAX_W) + LA_W'(wc_q);
        end else begin
          sj_q <= sj_q + TWC_W'(1);
        end
      end
      if (rd_valid_q) begin
        sw_q  <= sw_q + SUM_W'(w_pix);
        sww_q <= sww_q + SQS_W'(w_pix) * SQS_W'(w_pix);
        swt_q <= swt_q + SQS_W'(w_pix) * SQS_W'(t_pix);
        sqd_q <= sqd_q + SQS_W'(d_pix) * SQS_W'(d_pix);
      end
    end
  end

  // correlation: products, variances, magnitude search
  always_ff @(posedge clk_i) begin
    if (cmd_i.prod) begin
      p_nsww_q <= V_W'(n_e) * V_W'(sww_q);
      p_sw2_q  <= V_W'(sw_q) * V_W'(sw_q);
      p_nstt_q <= V_W'(n_e) * V_W'(tsq_q);
      p_st2_q  <= V_W'(tsum_q) * V_W'(tsum_q);
      p_nswt_q <= V_W'(n_e) * V_W'(swt_q);
      p_swst_q <= V_W'(sw_q) * V_W'(tsum_q);
    end
    if (cmd_i.diff) begin
      vw_q  <= p_nsww_q - p_sw2_q;
      vt_q  <= p_nstt_q - p_st2_q;
      neg_q <= p_nswt_q < p_swst_q;
      m_q   <= (p_nswt_q >= p_swst_q) ? p_nswt_q - p_swst_q : p_swst_q - p_nswt_q;
      lo_q  <= '0;
      hi_q  <= Q_ONE;
    end
    if (cmd_i.sq) begin
      pp_q    <= PP_W'(vw_q) * PP_W'(vt_q);
      aa_q    <= PP_W'(m_q) * PP_W'(m_q);
      degen_q <= (vw_q == '0) || (vt_q == '0);
    end
    if (cmd_i.k_step) begin
      mid_q <= mid_c;
      k2_q  <= K2_W'(k_wide[Q_W-1:0]) * K2_W'(k_wide[Q_W-1:0]);
    end
    if (cmd_i.mul_lo) begin
      pl_q <= MUL_W'(k2_q) * MUL_W'(pp_q[V_W-1:0]);
    end
    if (cmd_i.mul_hi) begin
      ph_q <= MUL_W'(k2_q) * MUL_W'(pp_q[PP_W-1:V_W]);
    end
    if (cmd_i.cmp) begin
      if (b_val <= a_val) begin
        lo_q <= mid_q;
      end else begin
        hi_q <= mid_q - Q_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.window_row   <= ROW_OUT_W'(wr_q);
      out_q.window_col   <= COL_OUT_W'(wc_q);
      out_q.last_result  <= last_q;
      out_q.sqdiff_score <= '0;
      out_q.ncc_score    <= '0;
      out_q.degenerate   <= 1'b0;
      if (mode_q == MODE_SQDIFF) begin
        out_q.sqdiff_score <= SQD_OUT_W'(sqd_q);
      end else if (degen_q) begin
        out_q.degenerate <= 1'b1;
      end else begin
        out_q.ncc_score <= ncc_val;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    status_o             = '0;
    status_o.hit         = hit;
    status_o.scan_last   = scan_last;
    status_o.mode        = mode_q;
    status_o.degen       = (vw_q == '0) || (vt_q == '0);
    status_o.search_done = lo_q == hi_q;
    status_o.out_free    = !out_valid_q || out_ready_i;
  end

  // template fill never passes the template size
  a_tcount_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tcount_q <= n_e)
    else $error("template count beyond template size");

  // scan reads stay inside the loaded template
  a_scan_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> N_W'(ta_q) < n_e)
    else $error("template read past end");

  // search only runs on an open interval
  a_search_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.k_step |-> lo_q < hi_q)
    else $error("search step on closed interval");

  // a loaded result is presented next cycle
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |=> out_valid_q)
    else $error("result not presented after load");

endmodule
